/* rtl/ssc_pkg.sv */
`timescale 1ns / 1ps

package ssc_pkg;

    localparam int CW = 32;                 // coordinate width
    localparam int NRM_W = 16;              // normal component width
    localparam int NRM_FRAC = 15;
    localparam int PRD_W = CW + NRM_W;      // one coordinate by normal product
    localparam int PRJ_W = PRD_W + 2;       // sum of three products
    localparam int NUM_W = PRJ_W + 1;       // plane minus projection
    localparam int MAG_W = NUM_W;           // magnitude of num / den
    localparam int DIF_W = CW + 1;          // end minus start
    localparam int K_BITS = 30;
    localparam int K_W = K_BITS + 1;        // factor including the value one
    localparam int MUL_W = 64;
    localparam int DIV_ST = K_BITS;         // one quotient bit per stage
    localparam int NST = 3 + DIV_ST + 2;    // total pipeline depth

    localparam logic [K_W-1:0] K_ONE = K_W'(1) << K_BITS;

    // register indexes
    localparam logic [2:0] REG_NX = 3'd0;
    localparam logic [2:0] REG_NY = 3'd1;
    localparam logic [2:0] REG_NZ = 3'd2;
    localparam logic [2:0] REG_LO = 3'd3;
    localparam logic [2:0] REG_HI = 3'd4;

    // combined region codes
    localparam logic [3:0] CODE_BOTH_BELOW = 4'd1;
    localparam logic [3:0] CODE_E_LO       = 4'd2;
    localparam logic [3:0] CODE_S_HI_E_LO  = 4'd3;
    localparam logic [3:0] CODE_S_LO       = 4'd4;
    localparam logic [3:0] CODE_S_HI       = 4'd6;
    localparam logic [3:0] CODE_S_LO_E_HI  = 4'd7;
    localparam logic [3:0] CODE_E_HI       = 4'd8;
    localparam logic [3:0] CODE_BOTH_ABOVE = 4'd9;

    typedef logic signed [CW-1:0] t_coord;
    typedef logic signed [NRM_W-1:0] t_nrm;

    typedef struct packed {
        t_coord start_x;
        t_coord start_y;
        t_coord start_z;
        t_coord end_x;
        t_coord end_y;
        t_coord end_z;
        logic   hide_in;
        logic   last_in;
    } t_in_item;

    typedef struct packed {
        t_coord     clip_start_x;
        t_coord     clip_start_y;
        t_coord     clip_start_z;
        t_coord     clip_end_x;
        t_coord     clip_end_y;
        t_coord     clip_end_z;
        logic       hide_out;
        logic [3:0] region_code;
        logic       last_out;
    } t_out_item;

    typedef struct packed {
        logic [2:0][CW-1:0]    s;
        logic [2:0][CW-1:0]    e;
        logic [2:0][DIF_W-1:0] d;
        logic [3:0]            code;
        logic                  hide;
        logic                  last;
    } t_side;

    typedef struct packed {
        logic [MAG_W-1:0]  r;
        logic [MAG_W-1:0]  ud;
        logic [K_BITS-1:0] q;
        logic              zero;
        logic              one;
    } t_div_st;

endpackage

/* rtl/ssc_in_if.sv */
`timescale 1ns / 1ps

interface ssc_in_if;
    import ssc_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* rtl/ssc_out_if.sv */
`timescale 1ns / 1ps

interface ssc_out_if;
    import ssc_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* rtl/segment_slab_clipper.sv */
`timescale 1ns / 1ps

// Segment slab clipper. Takes one 3D segment per cycle (Q23.8 endpoints) and
// clips it against the slab between two planes along a Q1.15 unit normal.
// The pipeline has three stages of projection and region coding, thirty
// stages of restoring division (one bit of the Q0.30 crossing factor per
// stage, both planes in parallel), a multiply stage and the output register.
// Throughput is one item per cycle; a stall at the output freezes the whole
// pipeline, so nothing is lost or repeated. Registers are written through a
// plain write port (index 0..2 normal x/y/z, 3 lower, 4 upper plane) and
// should only change while the pipeline is empty; other indexes are ignored.
module segment_slab_clipper (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    ssc_in_if.sink      i_seg,
    ssc_out_if.source   o_res
);
    import ssc_pkg::*;

    t_nrm   r_nx, r_ny, r_nz;
    t_coord r_lo, r_hi;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nx <= '0;
            r_ny <= '0;
            r_nz <= 16'sd32767;
            r_lo <= '0;
            r_hi <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_NX:  r_nx <= i_cfg_data[NRM_W-1:0];
                REG_NY:  r_ny <= i_cfg_data[NRM_W-1:0];
                REG_NZ:  r_nz <= i_cfg_data[NRM_W-1:0];
                REG_LO:  r_lo <= i_cfg_data;
                REG_HI:  r_hi <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // one valid bit per stage; the whole pipe moves unless the output is held
    logic [NST-1:0] r_vld;
    logic           en;

    assign en = ~r_vld[NST-1] | o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_vld <= '0;
        else if (en)
            r_vld <= {r_vld[NST-2:0], i_seg.valid};
    end

    assign i_seg.ready = en;
    assign o_res.valid = r_vld[NST-1];

    t_side   p_side, v_side;
    t_div_st p_d1, p_d2, v_d1, v_d2;

    ssc_proj u_proj (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_nx   (r_nx),
        .i_ny   (r_ny),
        .i_nz   (r_nz),
        .i_lo   (r_lo),
        .i_hi   (r_hi),
        .i_item (i_seg.data),
        .o_side (p_side),
        .o_d1   (p_d1),
        .o_d2   (p_d2)
    );

    ssc_div u_div (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_side (p_side),
        .i_d1   (p_d1),
        .i_d2   (p_d2),
        .o_side (v_side),
        .o_d1   (v_d1),
        .o_d2   (v_d2)
    );

    ssc_interp u_interp (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_side (v_side),
        .i_d1   (v_d1),
        .i_d2   (v_d2),
        .o_item (o_res.data)
    );

endmodule

/* rtl/ssc_proj.sv */
`timescale 1ns / 1ps

// projection, region coding and divider seeding: three stages
module ssc_proj (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  ssc_pkg::t_nrm         i_nx,
    input  ssc_pkg::t_nrm         i_ny,
    input  ssc_pkg::t_nrm         i_nz,
    input  ssc_pkg::t_coord       i_lo,
    input  ssc_pkg::t_coord       i_hi,
    input  ssc_pkg::t_in_item     i_item,
    output ssc_pkg::t_side        o_side,
    output ssc_pkg::t_div_st      o_d1,
    output ssc_pkg::t_div_st      o_d2
);
    import ssc_pkg::*;

    logic signed [PRD_W-1:0] r1_p [6];
    t_side                   r1_side;
    logic signed [PRJ_W-1:0] r2_ps, r2_pe;
    t_side                   r2_side;
    t_side                   r_side;
    t_div_st                 r_d1, r_d2;

    t_side n1_side;
    t_nrm  nrm [3];

    always_comb begin
        nrm[0] = i_nx;
        nrm[1] = i_ny;
        nrm[2] = i_nz;
        n1_side.s = {i_item.start_z, i_item.start_y, i_item.start_x};
        n1_side.e = {i_item.end_z, i_item.end_y, i_item.end_x};
        n1_side.d[0] = DIF_W'($signed(i_item.end_x)) - DIF_W'($signed(i_item.start_x));
        n1_side.d[1] = DIF_W'($signed(i_item.end_y)) - DIF_W'($signed(i_item.start_y));
        n1_side.d[2] = DIF_W'($signed(i_item.end_z)) - DIF_W'($signed(i_item.start_z));
        n1_side.code = CODE_BOTH_BELOW;
        n1_side.hide = i_item.hide_in;
        n1_side.last = i_item.last_in;
    end

    // stage 1: six products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r1_p[i]     <= $signed(n1_side.s[i]) * nrm[i];
                r1_p[i + 3] <= $signed(n1_side.e[i]) * nrm[i];
            end
            r1_side <= n1_side;
        end
    end

    // stage 2: projections
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_ps   <= PRJ_W'(r1_p[0]) + PRJ_W'(r1_p[1]) + PRJ_W'(r1_p[2]);
            r2_pe   <= PRJ_W'(r1_p[3]) + PRJ_W'(r1_p[4]) + PRJ_W'(r1_p[5]);
            r2_side <= r1_side;
        end
    end

    // stage 3: regions, numerators, divisor
    logic signed [NUM_W-1:0] lo_s, hi_s, ps, pe, num1, num2, den;
    logic [1:0] rs, re;
    t_div_st n_d1, n_d2;
    t_side   n3_side;

    function automatic t_div_st seed(input logic signed [NUM_W-1:0] num,
                                     input logic signed [NUM_W-1:0] dv);
        t_div_st          d;
        logic [MAG_W-1:0] un, ud;
        un = num[NUM_W-1] ? MAG_W'(-num) : MAG_W'(num);
        ud = dv[NUM_W-1] ? MAG_W'(-dv) : MAG_W'(dv);
        d.zero = (dv == '0) || (num == '0) || (num[NUM_W-1] != dv[NUM_W-1]);
        d.one  = (un >= ud);
        d.r    = un;
        d.ud   = ud;
        d.q    = '0;
        return d;
    endfunction

    always_comb begin
        lo_s = NUM_W'($signed(i_lo)) <<< NRM_FRAC;
        hi_s = NUM_W'($signed(i_hi)) <<< NRM_FRAC;
        ps   = NUM_W'(r2_ps);
        pe   = NUM_W'(r2_pe);
        num1 = lo_s - ps;
        num2 = hi_s - ps;
        den  = pe - ps;
        rs   = (ps > hi_s) ? 2'd2 : ((ps > lo_s) ? 2'd1 : 2'd0);
        re   = 2'(pe > lo_s) + 2'(pe > hi_s);
        n_d1 = seed(num1, den);
        n_d2 = seed(num2, den);
        n3_side      = r2_side;
        n3_side.code = 4'd1 + 4'(rs) + 4'd3 * 4'(re);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side <= n3_side;
            r_d1   <= n_d1;
            r_d2   <= n_d2;
        end
    end

    assign o_side = r_side;
    assign o_d1   = r_d1;
    assign o_d2   = r_d2;

endmodule

/* rtl/ssc_div.sv */
`timescale 1ns / 1ps

// two restoring dividers, one quotient bit per stage, item data alongside
module ssc_div (
    input  logic             i_clk,
    input  logic             i_en,
    input  ssc_pkg::t_side   i_side,
    input  ssc_pkg::t_div_st i_d1,
    input  ssc_pkg::t_div_st i_d2,
    output ssc_pkg::t_side   o_side,
    output ssc_pkg::t_div_st o_d1,
    output ssc_pkg::t_div_st o_d2
);
    import ssc_pkg::*;

    t_side   r_side [DIV_ST];
    t_div_st r_d1 [DIV_ST];
    t_div_st r_d2 [DIV_ST];

    function automatic t_div_st div_step(input t_div_st d);
        t_div_st          n;
        logic [MAG_W:0]   r2;
        n  = d;
        r2 = {d.r, 1'b0};
        if (r2 >= {1'b0, d.ud}) begin
            r2  = r2 - {1'b0, d.ud};
            n.q = {d.q[K_BITS-2:0], 1'b1};
        end else begin
            n.q = {d.q[K_BITS-2:0], 1'b0};
        end
        n.r = r2[MAG_W-1:0];
        return n;
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= i_side;
            r_d1[0]   <= div_step(i_d1);
            r_d2[0]   <= div_step(i_d2);
            for (int i = 1; i < DIV_ST; i++) begin
                r_side[i] <= r_side[i - 1];
                r_d1[i]   <= div_step(r_d1[i - 1]);
                r_d2[i]   <= div_step(r_d2[i - 1]);
            end
        end
    end

    assign o_side = r_side[DIV_ST - 1];
    assign o_d1   = r_d1[DIV_ST - 1];
    assign o_d2   = r_d2[DIV_ST - 1];

endmodule

/* rtl/ssc_interp.sv */
`timescale 1ns / 1ps

// crossing interpolation and endpoint selection: multiply stage, output stage
module ssc_interp (
    input  logic                i_clk,
    input  logic                i_en,
    input  ssc_pkg::t_side      i_side,
    input  ssc_pkg::t_div_st    i_d1,
    input  ssc_pkg::t_div_st    i_d2,
    output ssc_pkg::t_out_item  o_item
);
    import ssc_pkg::*;

    logic signed [MUL_W-1:0] r_m1 [3];
    logic signed [MUL_W-1:0] r_m2 [3];
    t_side                   r_side;
    t_out_item               r_item;

    logic [K_W-1:0] k1, k2;

    function automatic logic [K_W-1:0] factor(input t_div_st d);
        if (d.zero)
            return '0;
        else if (d.one)
            return K_ONE;
        else
            return {1'b0, d.q};
    endfunction

    always_comb begin
        k1 = factor(i_d1);
        k2 = factor(i_d2);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_m1[i] <= MUL_W'($signed(i_side.d[i])) * MUL_W'($signed({1'b0, k1}));
                r_m2[i] <= MUL_W'($signed(i_side.d[i])) * MUL_W'($signed({1'b0, k2}));
            end
            r_side <= i_side;
        end
    end

    logic signed [MUL_W-1:0] t1, t2;
    t_coord c1 [3];
    t_coord c2 [3];
    t_coord ns [3];
    t_coord ne [3];
    t_out_item n_item;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            t1    = (r_m1[i] + MUL_W'(64'sd1 <<< (K_BITS - 1))) >>> K_BITS;
            t2    = (r_m2[i] + MUL_W'(64'sd1 <<< (K_BITS - 1))) >>> K_BITS;
            c1[i] = r_side.s[i] + t1[CW-1:0];
            c2[i] = r_side.s[i] + t2[CW-1:0];
            ns[i] = r_side.s[i];
            ne[i] = r_side.e[i];
            case (r_side.code)
                CODE_S_LO:      ns[i] = c1[i];
                CODE_E_LO:      ne[i] = c1[i];
                CODE_E_HI:      ne[i] = c2[i];
                CODE_S_HI:      ns[i] = c2[i];
                CODE_S_LO_E_HI: begin
                    ns[i] = c1[i];
                    ne[i] = c2[i];
                end
                CODE_S_HI_E_LO: begin
                    ns[i] = c2[i];
                    ne[i] = c1[i];
                end
                default: ;
            endcase
        end
        n_item.clip_start_x = ns[0];
        n_item.clip_start_y = ns[1];
        n_item.clip_start_z = ns[2];
        n_item.clip_end_x   = ne[0];
        n_item.clip_end_y   = ne[1];
        n_item.clip_end_z   = ne[2];
        n_item.hide_out     = (r_side.code == CODE_BOTH_BELOW) ||
                              (r_side.code == CODE_BOTH_ABOVE) || r_side.hide;
        n_item.region_code  = r_side.code;
        n_item.last_out     = r_side.last;
    end

    always_ff @(posedge i_clk) begin
        if (i_en)
            r_item <= n_item;
    end

    assign o_item = r_item;

endmodule

/* dv/tb_segment_slab_clipper.sv */
`timescale 1ns / 1ps

module tb_segment_slab_clipper;
    import ssc_pkg::*;

    // Pipeline is 35 deep; it is drained before touching config.
    localparam int DRAIN_CYCLES = 48;
    localparam int CYCLE_LIMIT = 600000;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [31:0] i_cfg_data;

    ssc_in_if  seg_if ();
    ssc_out_if res_if ();

    segment_slab_clipper u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_seg      (seg_if),
        .o_res      (res_if)
    );

    // Local copy of the slab registers, kept in step with every write.
    t_nrm   slab_nrm [3];
    t_coord slab_lo;
    t_coord slab_hi;

    t_out_item clipped_q [$];
    int        err_cnt = 0;
    int        cyc_cnt = 0;

    // Sender burst state
    int burst_left;
    int gap_max;
    // Receiver stall pattern
    int stall_period;
    int stall_len;
    int stall_phase;

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cyc_cnt <= cyc_cnt + 1;
        if (cyc_cnt > CYCLE_LIMIT) begin
            $display("segment_slab_clipper regression: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Q0.30 crossing factor num/den, saturating to [0, 1].
    function automatic longint unsigned cross_factor(longint num, longint den);
        longint unsigned un, ud, rem, q;
        q = 0;
        if (den == 0 || num == 0) return 0;
        if ((num < 0) != (den < 0)) return 0;
        un = (num < 0) ? longint'(-num) : num;
        ud = (den < 0) ? longint'(-den) : den;
        if (un >= ud) return 64'd1 << K_BITS;
        rem = un;
        for (int i = 0; i < K_BITS; i++) begin
            rem = rem << 1;
            q = q << 1;
            if (rem >= ud) begin
                rem = rem - ud;
                q = q | 64'd1;
            end
        end
        return q;
    endfunction

    // a + round_half_up((b - a) * k / 2^30)
    function automatic t_coord lerp_coord(longint a, longint b, longint unsigned k);
        longint prod;
        prod = (b - a) * longint'(k);
        return t_coord'(a + ((prod + (longint'(1) << (K_BITS - 1))) >>> K_BITS));
    endfunction

    function automatic t_out_item clip_segment(t_in_item seg);
        t_out_item r;
        longint s [3];
        longint e [3];
        longint ps, pe, lo, hi;
        longint unsigned k_lo, k_hi;
        t_coord ns [3];
        t_coord ne [3];
        t_coord c_lo, c_hi;
        int rs, re;
        logic [3:0] code;

        s[0] = seg.start_x; s[1] = seg.start_y; s[2] = seg.start_z;
        e[0] = seg.end_x;   e[1] = seg.end_y;   e[2] = seg.end_z;
        ps = 0;
        pe = 0;
        for (int i = 0; i < 3; i++) begin
            ps += s[i] * longint'(slab_nrm[i]);
            pe += e[i] * longint'(slab_nrm[i]);
        end
        // planes scaled into the Q.23 projection domain
        lo = longint'(slab_lo) <<< NRM_FRAC;
        hi = longint'(slab_hi) <<< NRM_FRAC;

        // start and end use different tie rules on purpose (inverted slab)
        rs = (ps > hi) ? 2 : ((ps > lo) ? 1 : 0);
        re = int'(pe > lo) + int'(pe > hi);
        code = 4'(1 + rs + 3 * re);

        k_lo = cross_factor(lo - ps, pe - ps);
        k_hi = cross_factor(hi - ps, pe - ps);

        for (int i = 0; i < 3; i++) begin
            c_lo = lerp_coord(s[i], e[i], k_lo);
            c_hi = lerp_coord(s[i], e[i], k_hi);
            ns[i] = t_coord'(s[i]);
            ne[i] = t_coord'(e[i]);
            case (code)
                CODE_S_LO: ns[i] = c_lo;
                CODE_E_LO: ne[i] = c_lo;
                CODE_E_HI: ne[i] = c_hi;
                CODE_S_HI: ns[i] = c_hi;
                CODE_S_LO_E_HI: begin
                    ns[i] = c_lo;
                    ne[i] = c_hi;
                end
                CODE_S_HI_E_LO: begin
                    ns[i] = c_hi;
                    ne[i] = c_lo;
                end
                default: ;
            endcase
        end

        r.clip_start_x = ns[0]; r.clip_start_y = ns[1]; r.clip_start_z = ns[2];
        r.clip_end_x   = ne[0]; r.clip_end_y   = ne[1]; r.clip_end_z   = ne[2];
        r.hide_out = (code == CODE_BOTH_BELOW || code == CODE_BOTH_ABOVE) ? 1'b1
                                                                          : seg.hide_in;
        r.region_code = code;
        r.last_out = seg.last_in;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Receiver: ready follows a repeating low window whose shape changes
    // every so often; stall_len of zero means no back-pressure at all.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
            stall_phase <= 0;
            stall_period = 4;
            stall_len = 0;
        end else begin
            if (stall_phase >= stall_period - 1) begin
                stall_phase <= 0;
                if ($urandom_range(0, 3) == 0) begin
                    stall_period = $urandom_range(2, 16);
                    stall_len = ($urandom_range(0, 2) == 0) ? 0
                                                            : $urandom_range(0, stall_period - 1);
                end
            end else begin
                stall_phase <= stall_phase + 1;
            end
            res_if.ready <= (stall_phase >= stall_len);
        end
    end

    // Check at the falling edge: the values seen here are the ones the
    // next rising edge will accept.
    always @(negedge i_clk) begin
        t_out_item want, got;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            got = res_if.data;
            if (clipped_q.size() == 0) begin
                $error("result item with nothing expected");
                err_cnt++;
            end else begin
                want = clipped_q.pop_front();
                if (got.clip_start_x !== want.clip_start_x) begin
                    $error("clip_start_x exp %0d got %0d", want.clip_start_x, got.clip_start_x);
                    err_cnt++;
                end
                if (got.clip_start_y !== want.clip_start_y) begin
                    $error("clip_start_y exp %0d got %0d", want.clip_start_y, got.clip_start_y);
                    err_cnt++;
                end
                if (got.clip_start_z !== want.clip_start_z) begin
                    $error("clip_start_z exp %0d got %0d", want.clip_start_z, got.clip_start_z);
                    err_cnt++;
                end
                if (got.clip_end_x !== want.clip_end_x) begin
                    $error("clip_end_x exp %0d got %0d", want.clip_end_x, got.clip_end_x);
                    err_cnt++;
                end
                if (got.clip_end_y !== want.clip_end_y) begin
                    $error("clip_end_y exp %0d got %0d", want.clip_end_y, got.clip_end_y);
                    err_cnt++;
                end
                if (got.clip_end_z !== want.clip_end_z) begin
                    $error("clip_end_z exp %0d got %0d", want.clip_end_z, got.clip_end_z);
                    err_cnt++;
                end
                if (got.hide_out !== want.hide_out) begin
                    $error("hide_out exp %0d got %0d", want.hide_out, got.hide_out);
                    err_cnt++;
                end
                if (got.region_code !== want.region_code) begin
                    $error("region_code exp %0d got %0d", want.region_code, got.region_code);
                    err_cnt++;
                end
                if (got.last_out !== want.last_out) begin
                    $error("last_out exp %0d got %0d", want.last_out, got.last_out);
                    err_cnt++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender and register access
    // ------------------------------------------------------------------

    // Drive one item, holding valid across items inside a burst; the item
    // is accepted at the rising edge following a falling edge with ready.
    task automatic send_segment(input t_in_item seg);
        int gap;
        logic took;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            if (gap > 0) begin
                seg_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        seg_if.valid <= 1'b1;
        seg_if.data <= seg;
        do begin
            @(negedge i_clk);
            took = seg_if.ready;
            @(posedge i_clk);
        end while (!took);
        clipped_q.push_back(clip_segment(seg));
    endtask

    // Park the input and let the pipeline empty before a register write.
    task automatic drain_pipe();
        seg_if.valid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (clipped_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Leaves the write enable high; the caller drops it after the last write.
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        case (idx)
            REG_NX: slab_nrm[0] = value[15:0];
            REG_NY: slab_nrm[1] = value[15:0];
            REG_NZ: slab_nrm[2] = value[15:0];
            REG_LO: slab_lo = value;
            REG_HI: slab_hi = value;
            default: ;  // unmapped index, ignored by the block
        endcase
    endtask

    task automatic set_slab(input t_nrm nx, input t_nrm ny, input t_nrm nz,
                            input t_coord lo, input t_coord hi);
        drain_pipe();
        write_reg(REG_NX, 32'(unsigned'(nx)));
        write_reg(REG_NY, 32'(unsigned'(ny)));
        write_reg(REG_NZ, 32'(unsigned'(nz)));
        write_reg(REG_LO, lo);
        write_reg(REG_HI, hi);
        // a stray write to an unmapped index must leave everything alone
        write_reg(3'($urandom_range(5, 7)), $urandom);
        i_cfg_we <= 1'b0;
    endtask

    function automatic t_in_item make_seg(input t_coord sx, input t_coord sy, input t_coord sz,
                                          input t_coord ex, input t_coord ey, input t_coord ez,
                                          input logic hide, input logic last);
        t_in_item seg;
        seg.start_x = sx; seg.start_y = sy; seg.start_z = sz;
        seg.end_x = ex;   seg.end_y = ey;   seg.end_z = ez;
        seg.hide_in = hide;
        seg.last_in = last;
        return seg;
    endfunction

    // Mostly coordinates near the slab so every region pair shows up;
    // now and then a full-width value to toggle every bit.
    function automatic t_coord rand_coord();
        if ($urandom_range(0, 9) == 0) return t_coord'($urandom);
        return t_coord'(int'($urandom_range(0, 32767)) - 16384);
    endfunction

    function automatic t_in_item rand_seg();
        t_in_item seg;
        seg = make_seg(rand_coord(), rand_coord(), rand_coord(),
                       rand_coord(), rand_coord(), rand_coord(),
                       $urandom_range(0, 1), $urandom_range(0, 1));
        // sometimes a degenerate segment with both ends the same
        if ($urandom_range(0, 19) == 0) begin
            seg.end_x = seg.start_x;
            seg.end_y = seg.start_y;
            seg.end_z = seg.start_z;
        end
        return seg;
    endfunction

    function automatic t_coord rand_plane();
        return t_coord'(int'($urandom_range(0, 16383)) - 8192);
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset slab (z normal, both planes at zero): crossings land on zero.
    task automatic test_reset_slab();
        gap_max = 0;
        send_segment(make_seg(10, 20, -500, -30, 40, 500, 1'b0, 1'b0));
        send_segment(make_seg(10, 20, 500, -30, 40, -500, 1'b0, 1'b1));
        send_segment(make_seg(1, 2, -5, 3, 4, -9, 1'b0, 1'b0));
    endtask

    // Every region pair against a z slab of [-1000, 1000].
    task automatic test_region_codes();
        t_coord zs [3];
        zs[0] = -2000; zs[1] = 0; zs[2] = 2000;
        set_slab(16'sd0, 16'sd0, 16'sd32767, -32'sd1000, 32'sd1000);
        gap_max = 3;
        for (int a = 0; a < 3; a++)
            for (int b = 0; b < 3; b++)
                send_segment(make_seg(100, -200, zs[a], -300, 400, zs[b],
                                      1'b0, (a == 2 && b == 2)));
        // hidden input still gets clipped; hidden output keeps coordinates
        send_segment(make_seg(5, 5, -3000, 7, 7, 3000, 1'b1, 1'b0));
        send_segment(make_seg(5, 5, 3000, 7, 7, 2500, 1'b1, 1'b1));
    endtask

    // Upper below lower: factors saturate, start and end tie rules differ,
    // and equal projections give a zero factor.
    task automatic test_inverted_slab();
        set_slab(16'sd0, 16'sd0, 16'sd32767, 32'sd1000, -32'sd1000);
        gap_max = 2;
        send_segment(make_seg(1, 2, 0, 3, 4, 0, 1'b0, 1'b0));
        send_segment(make_seg(1, 2, -50, 3, 4, 50, 1'b0, 1'b0));
        send_segment(make_seg(1, 2, 3000, 3, 4, -3000, 1'b0, 1'b0));
        send_segment(make_seg(1, 2, -3000, 3, 4, 3000, 1'b0, 1'b1));
    endtask

    // Extreme normals and coordinates, extreme plane offsets.
    task automatic test_extremes();
        set_slab(-16'sd32768, 16'sd32767, -16'sd32768,
                 -32'sd2147483648, 32'sd2147483647);
        gap_max = 1;
        send_segment(make_seg(32'h7fffffff, 32'h80000000, 32'h7fffffff,
                              32'h80000000, 32'h7fffffff, 32'h80000000, 1'b1, 1'b1));
        send_segment(make_seg(32'h80000000, 32'h80000000, 32'h80000000,
                              32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1'b0, 1'b0));
        send_segment(make_seg(0, 0, 0, 32'hffffffff, 32'hffffffff, 32'hffffffff, 1'b0, 1'b1));
        set_slab(-16'sd32768, 16'sd32767, -16'sd32768, 32'sd0, 32'sd256);
        send_segment(make_seg(32'h7fffffff, 32'h80000000, 32'h7fffffff,
                              32'h80000000, 32'h7fffffff, 32'h80000000, 1'b0, 1'b0));
        send_segment(make_seg(32'h80000000, 32'h7fffffff, 32'h80000000,
                              32'h7fffffff, 32'h80000000, 32'h7fffffff, 1'b1, 1'b0));
    endtask

    // Random segments over a sequence of slabs: normal ones, inverted ones,
    // ones with full-range registers and ones with both planes equal.
    task automatic test_random_segments();
        t_coord a, b;
        for (int ph = 0; ph < 10; ph++) begin
            a = rand_plane();
            b = rand_plane();
            case (ph % 5)
                0: set_slab(16'sd0, 16'sd0, 16'sd32767, (a < b) ? a : b, (a < b) ? b : a);
                1: set_slab(t_nrm'($urandom), t_nrm'($urandom), t_nrm'($urandom),
                            (a < b) ? a : b, (a < b) ? b : a);
                2: set_slab(t_nrm'($urandom), t_nrm'($urandom), t_nrm'($urandom),
                            (a < b) ? b : a, (a < b) ? a : b);
                3: set_slab(t_nrm'($urandom), t_nrm'($urandom), t_nrm'($urandom),
                            t_coord'($urandom), t_coord'($urandom));
                default: set_slab(16'sd23170, -16'sd23170, 16'sd0, a, a);
            endcase
            // alternate heavy, light and no sender gaps between phases
            gap_max = (ph % 3 == 0) ? 0 : ((ph % 3 == 1) ? 3 : 12);
            repeat (130) send_segment(rand_seg());
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        seg_if.valid = 1'b0;
        seg_if.data = '0;
        burst_left = 0;
        gap_max = 0;
        slab_nrm[0] = 16'sd0;
        slab_nrm[1] = 16'sd0;
        slab_nrm[2] = 16'sd32767;
        slab_lo = 0;
        slab_hi = 0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_slab();
        test_region_codes();
        test_inverted_slab();
        test_extremes();
        test_random_segments();

        drain_pipe();
        if (err_cnt == 0) begin
            $display("segment_slab_clipper regression: pass");
        end else begin
            $display("segment_slab_clipper regression: fail");
        end
        $finish;
    end

endmodule
